FILE: rtl/flow_tuple_counter_macros.svh
// Assertion macros for the flow tuple counter RTL.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef FLOW_TUPLE_COUNTER_MACROS_SVH
`define FLOW_TUPLE_COUNTER_MACROS_SVH
`ifndef SYNTH
`define FTC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flow tuple counter check failed");
`define FTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flow tuple counter check failed");
`else
`define FTC_ASSERT_IMPLIES(label, ante, cons)
`define FTC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/ftc_pkg.sv
// Shared types and constants for the flow tuple counter.
// No dependencies; used by every RTL file of the block.
package ftc_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 1024;

  localparam logic [2:0] ST_DISABLED = 3'd0;
  localparam logic [2:0] ST_NOT_IP   = 3'd1;
  localparam logic [2:0] ST_UPDATED  = 3'd2;
  localparam logic [2:0] ST_CREATED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_VALID    = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic [3:0] FAM_IPV4 = 4'd2;
  localparam logic [3:0] FAM_IPV6 = 4'd10;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic [63:0] timestamp;
    logic [9:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    logic [3:0]  family;
    logic [7:0]  protocol;
    logic [63:0] packet_count;
    logic [63:0] byte_count;
    logic [63:0] latest_stamp;
  } out_t;

  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    logic [3:0]  family;
    logic [7:0]  protocol;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [63:0] seen;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_READ,
    CMD_FRAME
  } cmd_kind_t;

  // One transfer from the parser to the table engine
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  status;
    key_t        key;
    logic [15:0] len;
    logic [63:0] stamp;
    logic [9:0]  entry_index;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_CMP,
    S_READ_OUT,
    S_MISS
  } eng_state_t;

  function automatic out_t make_result(logic [2:0] st, key_t k, logic [63:0] pk,
                                       logic [63:0] by, logic [63:0] tm);
    out_t r;
    r.status       = st;
    r.src_addr_hi  = k.src_hi;
    r.src_addr_lo  = k.src_lo;
    r.dst_addr_hi  = k.dst_hi;
    r.dst_addr_lo  = k.dst_lo;
    r.l4_src       = k.l4_src;
    r.l4_dst       = k.l4_dst;
    r.family       = k.family;
    r.protocol     = k.protocol;
    r.packet_count = pk;
    r.byte_count   = by;
    r.latest_stamp = tm;
    return r;
  endfunction

endpackage

FILE: rtl/ftc_front.sv
// Byte parser: extracts the flow key from each frame and issues commands.
// Depends on ftc_pkg.
module ftc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ftc_pkg::in_t  item,
  input  logic          capture_enable,
  output logic          push,
  output ftc_pkg::cmd_t cmd
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] frame_ethertype, frame_ethertype_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  cur_protocol, cur_protocol_next;
  logic [63:0] cur_src_hi, cur_src_hi_next;
  logic [63:0] cur_src_lo, cur_src_lo_next;
  logic [63:0] cur_dst_hi, cur_dst_hi_next;
  logic [63:0] cur_dst_lo, cur_dst_lo_next;
  logic [31:0] cur_ports, cur_ports_next;

  logic [15:0] off;
  logic [16:0] l4_pos;
  logic [16:0] l4_end;
  logic [4:0]  need;
  logic [3:0]  fam;
  logic        is_ip;
  logic        byte_in;

  // OR byte b into big-endian lane k of a word
  function automatic logic [63:0] put8(logic [63:0] w, logic [2:0] k, logic [7:0] b);
    return w | ({56'd0, b} << (6'd56 - {k, 3'b000}));
  endfunction

  assign byte_in = accept && !item.action;
  assign off     = byte_position - 16'd14;

  // Parse the incoming byte
  always_comb begin
    frame_ethertype_next = frame_ethertype;
    header_words_next    = header_words;
    cur_protocol_next    = cur_protocol;
    cur_src_hi_next      = cur_src_hi;
    cur_src_lo_next      = cur_src_lo;
    cur_dst_hi_next      = cur_dst_hi;
    cur_dst_lo_next      = cur_dst_lo;
    cur_ports_next       = cur_ports;
    l4_pos               = 17'd54;
    if (byte_position == 16'd12) begin
      frame_ethertype_next = {item.data_byte, 8'h00};
    end
    if (byte_position == 16'd13) begin
      frame_ethertype_next = {frame_ethertype[15:8], item.data_byte};
    end
    if (byte_position >= 16'd14) begin
      if (frame_ethertype == ftc_pkg::ETH_IPV4) begin
        if (off == 16'd0) header_words_next = item.data_byte[3:0];
        if (off == 16'd9) cur_protocol_next = item.data_byte;
        if (off >= 16'd12 && off < 16'd16) begin
          cur_src_hi_next = put8(cur_src_hi, off[2:0] - 3'd4, item.data_byte);
        end
        if (off >= 16'd16 && off < 16'd20) begin
          cur_dst_hi_next = put8(cur_dst_hi, off[2:0], item.data_byte);
        end
        l4_pos = 17'd14 + {11'd0, header_words_next, 2'b00};
        if ({1'b0, byte_position} >= l4_pos && {1'b0, byte_position} < l4_pos + 17'd4) begin
          cur_ports_next = cur_ports | ({24'd0, item.data_byte} <<
                           (5'd24 - {byte_position[1:0] - l4_pos[1:0], 3'b000}));
        end
      end else if (frame_ethertype == ftc_pkg::ETH_IPV6) begin
        if (off == 16'd6) cur_protocol_next = item.data_byte;
        if (off >= 16'd8 && off < 16'd16) begin
          cur_src_hi_next = put8(cur_src_hi, off[2:0], item.data_byte);
        end
        if (off >= 16'd16 && off < 16'd24) begin
          cur_src_lo_next = put8(cur_src_lo, off[2:0], item.data_byte);
        end
        if (off >= 16'd24 && off < 16'd32) begin
          cur_dst_hi_next = put8(cur_dst_hi, off[2:0], item.data_byte);
        end
        if (off >= 16'd32 && off < 16'd40) begin
          cur_dst_lo_next = put8(cur_dst_lo, off[2:0], item.data_byte);
        end
        if (byte_position >= 16'd54 && byte_position < 16'd58) begin
          cur_ports_next = cur_ports | ({24'd0, item.data_byte} <<
                           (5'd24 - {byte_position[1:0] - 2'd2, 3'b000}));
        end
      end
    end
    byte_position_next = (byte_position == 16'hFFFF) ? byte_position
                                                     : byte_position + 16'd1;
  end

  // Classify the frame at its last byte
  always_comb begin
    is_ip  = 1'b0;
    fam    = 4'd0;
    l4_end = 17'd54;
    need   = 5'd0;
    if (frame_ethertype_next == ftc_pkg::ETH_IPV4 && byte_position_next >= 16'd34) begin
      is_ip  = 1'b1;
      fam    = ftc_pkg::FAM_IPV4;
      l4_end = 17'd14 + {11'd0, header_words_next, 2'b00};
    end else if (frame_ethertype_next == ftc_pkg::ETH_IPV6 &&
                 byte_position_next >= 16'd54) begin
      is_ip = 1'b1;
      fam   = ftc_pkg::FAM_IPV6;
    end
    if (cur_protocol_next == ftc_pkg::PROTO_TCP) need = 5'd20;
    else if (cur_protocol_next == ftc_pkg::PROTO_UDP) need = 5'd8;
  end

  // Build the command handed to the table engine
  always_comb begin
    cmd              = '0;
    cmd.stamp        = item.timestamp;
    cmd.entry_index  = item.entry_index;
    cmd.len          = byte_position_next;
    cmd.key.src_hi   = cur_src_hi_next;
    cmd.key.src_lo   = cur_src_lo_next;
    cmd.key.dst_hi   = cur_dst_hi_next;
    cmd.key.dst_lo   = cur_dst_lo_next;
    cmd.key.family   = fam;
    cmd.key.protocol = cur_protocol_next;
    if (need != 5'd0 && {1'b0, byte_position_next} >= l4_end + {12'd0, need}) begin
      cmd.key.l4_src = cur_ports_next[31:16];
      cmd.key.l4_dst = cur_ports_next[15:0];
    end
    if (item.action) begin
      cmd.kind = ftc_pkg::CMD_READ;
      cmd.key  = '0;
    end else if (!capture_enable) begin
      cmd.kind   = ftc_pkg::CMD_REPORT;
      cmd.status = ftc_pkg::ST_DISABLED;
    end else if (!is_ip) begin
      cmd.kind   = ftc_pkg::CMD_REPORT;
      cmd.status = ftc_pkg::ST_NOT_IP;
    end else begin
      cmd.kind = ftc_pkg::CMD_FRAME;
    end
  end

  assign push = accept && (item.action || item.end_of_frame);

  // Advance the frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (byte_in && item.end_of_frame)) begin
      byte_position   <= '0;
      frame_ethertype <= '0;
      header_words    <= '0;
      cur_protocol    <= '0;
      cur_src_hi      <= '0;
      cur_src_lo      <= '0;
      cur_dst_hi      <= '0;
      cur_dst_lo      <= '0;
      cur_ports       <= '0;
    end else if (byte_in) begin
      byte_position   <= byte_position_next;
      frame_ethertype <= frame_ethertype_next;
      header_words    <= header_words_next;
      cur_protocol    <= cur_protocol_next;
      cur_src_hi      <= cur_src_hi_next;
      cur_src_lo      <= cur_src_lo_next;
      cur_dst_hi      <= cur_dst_hi_next;
      cur_dst_lo      <= cur_dst_lo_next;
      cur_ports       <= cur_ports_next;
    end
  end

endmodule

FILE: rtl/ftc_queue.sv
// Two-entry command queue between the parser and the table engine.
// Depends on ftc_pkg and the assertion macro header.
`include "flow_tuple_counter_macros.svh"
module ftc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ftc_pkg::cmd_t push_data,
  input  logic          pop,
  output ftc_pkg::cmd_t pop_data,
  output logic          empty,
  output logic          full
);

  ftc_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `FTC_ASSERT_IMPLIES(a_no_overflow, push, !full || pop)
  `FTC_ASSERT_IMPLIES(a_no_underflow, pop, !empty)
  `FTC_ASSERT_NEXT(a_count_push, push && !pop, count == $past(count) + 2'd1)

endmodule

FILE: rtl/ftc_back.sv
// Table engine: searches, updates, creates and dumps flow entries.
// Depends on ftc_pkg and the assertion macro header.
`include "flow_tuple_counter_macros.svh"
module ftc_back #(
  parameter int TABLE_ENTRIES = ftc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ftc_pkg::cmd_t q_data,
  output logic          pop,
  output logic          result_strobe,
  output ftc_pkg::out_t result
);

  localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int CW1 = CW + 1;
  localparam int XW  = (CW > 10) ? CW : 10;

  ftc_pkg::eng_state_t state, state_next;
  ftc_pkg::cmd_t       cmd;
  ftc_pkg::entry_t     mem [TABLE_ENTRIES];
  ftc_pkg::entry_t     rd_data;
  ftc_pkg::entry_t     wdata;
  ftc_pkg::out_t       res_next;

  logic [AW-1:0] scan;
  logic [CW-1:0] entries_used;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic          res_load;
  logic          used_inc;
  logic          scan_clr;
  logic          scan_inc;
  logic          hit;
  logic          more;
  logic          in_range;
  logic          table_full;

  assign hit        = (rd_data.key == cmd.key);
  assign more       = (CW1'(scan) + CW1'(1)) < CW1'(entries_used);
  assign in_range   = XW'(cmd.entry_index) < XW'(entries_used);
  assign table_full = (entries_used == CW'(TABLE_ENTRIES));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ftc_pkg::S_IDLE: begin
        if (!q_empty) state_next = ftc_pkg::S_DISPATCH;
      end
      ftc_pkg::S_DISPATCH: begin
        unique case (cmd.kind)
          ftc_pkg::CMD_READ:  state_next = in_range ? ftc_pkg::S_READ_OUT : ftc_pkg::S_IDLE;
          ftc_pkg::CMD_FRAME: state_next = (entries_used != '0) ? ftc_pkg::S_SCAN_CMP
                                                                : ftc_pkg::S_MISS;
          default:            state_next = ftc_pkg::S_IDLE;
        endcase
      end
      ftc_pkg::S_SCAN_CMP: begin
        if (hit)       state_next = ftc_pkg::S_IDLE;
        else if (!more) state_next = ftc_pkg::S_MISS;
      end
      ftc_pkg::S_READ_OUT: state_next = ftc_pkg::S_IDLE;
      ftc_pkg::S_MISS:     state_next = ftc_pkg::S_IDLE;
      default:             state_next = ftc_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory access, result and counters
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    res_load = 1'b0;
    res_next = '0;
    used_inc = 1'b0;
    scan_clr = 1'b0;
    scan_inc = 1'b0;
    unique case (state)
      ftc_pkg::S_IDLE: begin
        pop = !q_empty;
      end
      ftc_pkg::S_DISPATCH: begin
        unique case (cmd.kind)
          ftc_pkg::CMD_READ: begin
            if (in_range) begin
              rd_en   = 1'b1;
              rd_addr = AW'(cmd.entry_index);
            end else begin
              res_load        = 1'b1;
              res_next.status = ftc_pkg::ST_EMPTY;
            end
          end
          ftc_pkg::CMD_FRAME: begin
            scan_clr = 1'b1;
            rd_en    = (entries_used != '0);
          end
          default: begin
            res_load        = 1'b1;
            res_next.status = cmd.status;
          end
        endcase
      end
      ftc_pkg::S_SCAN_CMP: begin
        if (hit) begin
          we            = 1'b1;
          waddr         = scan;
          wdata.key     = rd_data.key;
          wdata.packets = rd_data.packets + 64'd1;
          wdata.bytes   = rd_data.bytes + {48'd0, cmd.len};
          wdata.seen    = cmd.stamp;
          res_load      = 1'b1;
          res_next      = ftc_pkg::make_result(ftc_pkg::ST_UPDATED, cmd.key,
                                               wdata.packets, wdata.bytes, wdata.seen);
        end else if (more) begin
          rd_en    = 1'b1;
          rd_addr  = scan + AW'(1);
          scan_inc = 1'b1;
        end
      end
      ftc_pkg::S_READ_OUT: begin
        res_load = 1'b1;
        res_next = ftc_pkg::make_result(ftc_pkg::ST_VALID, rd_data.key,
                                        rd_data.packets, rd_data.bytes, rd_data.seen);
      end
      ftc_pkg::S_MISS: begin
        res_load = 1'b1;
        if (table_full) begin
          res_next = ftc_pkg::make_result(ftc_pkg::ST_FULL, cmd.key, '0, '0, '0);
        end else begin
          we            = 1'b1;
          waddr         = AW'(entries_used);
          wdata.key     = cmd.key;
          wdata.packets = 64'd1;
          wdata.bytes   = {48'd0, cmd.len};
          wdata.seen    = cmd.stamp;
          used_inc      = 1'b1;
          res_next      = ftc_pkg::make_result(ftc_pkg::ST_CREATED, cmd.key,
                                               wdata.packets, wdata.bytes, wdata.seen);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Flow table memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Hold the current command, scan position and result
  always_ff @(posedge clk) begin
    if (pop) cmd <= q_data;
    if (scan_clr) scan <= '0;
    else if (scan_inc) scan <= scan + AW'(1);
    if (res_load) result <= res_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ftc_pkg::S_IDLE;
      entries_used  <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= res_load;
      if (used_inc) entries_used <= entries_used + CW'(1);
    end
  end

  `FTC_ASSERT_IMPLIES(a_used_bound, 1'b1, entries_used <= CW'(TABLE_ENTRIES))
  `FTC_ASSERT_IMPLIES(a_write_state, we, state == ftc_pkg::S_SCAN_CMP || state == ftc_pkg::S_MISS)
  `FTC_ASSERT_NEXT(a_create_counts, used_inc, entries_used == $past(entries_used) + CW'(1))
  `FTC_ASSERT_NEXT(a_result_idle, res_load, state == ftc_pkg::S_IDLE && result_strobe)

endmodule

FILE: rtl/flow_tuple_counter.sv
// Flow tuple counter top level: parser, command queue and table engine.
// Depends on ftc_pkg, ftc_front, ftc_queue and ftc_back.
//
//   channel   handshake                 payload
//   input     start, busy               item   (ftc_pkg::in_t)
//   result    result_strobe (1 cycle)   result (ftc_pkg::out_t)
//   config    cfg_we                    cfg_data (capture_enable)
//
// Frame bytes are taken one per cycle while busy is low; busy is high
// only while the two-entry command queue is full. A frame compares the
// entries in use from entry 0, one compare per cycle through the table
// port, up to the first hit; a miss creates an entry or reports full.
// Results are registered with their strobe; the receiver cannot stall.
// Synchronous reset empties the table (entry count to zero) at once.
module flow_tuple_counter #(
  parameter int TABLE_ENTRIES = ftc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ftc_pkg::in_t  item,
  input  logic          cfg_we,
  input  logic          cfg_data,
  output logic          result_strobe,
  output ftc_pkg::out_t result
);

  logic          capture_enable;
  logic          accept;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  ftc_pkg::cmd_t push_data;
  ftc_pkg::cmd_t pop_data;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) capture_enable <= 1'b0;
    else if (cfg_we) capture_enable <= cfg_data;
  end

  ftc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .capture_enable (capture_enable),
    .push           (push),
    .cmd            (push_data)
  );

  ftc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  ftc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
